@@ src/ffba_pkg.sv @@
`default_nettype none

package ffba_pkg;

	// Default table geometry.
	localparam int NUM_PARTITIONS_DEF = 64;
	localparam int SIZE_BITS_DEF      = 16;

	// Fixed port widths of the request and result words.
	localparam int REQ_W    = 2;
	localparam int AMOUNT_W = 16;
	localparam int INDEX_W  = 6;
	localparam int STATUS_W = 3;

	typedef enum logic [REQ_W-1:0] {
		REQ_ADD   = 2'd0,
		REQ_ALLOC = 2'd1,
		REQ_FREE  = 2'd2,
		REQ_RSVD  = 2'd3
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 3'd0,
		ST_FULL   = 3'd1,
		ST_NOFIT  = 3'd2,
		ST_BADIDX = 3'd3,
		ST_FREED  = 3'd4
	} status_t;

endpackage

`default_nettype wire

@@ src/ffba_part_mem.sv @@
`default_nettype none

// Partition table: one write port and one read port, read data registered.
module ffba_part_mem #(
	parameter int DEPTH  = 64,
	parameter int WIDTH  = 17,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[raddr];
	end

	assign rdata = rd_data_q;

endmodule

`default_nettype wire

@@ src/first_fit_block_allocator.sv @@
`default_nettype none

// First-fit allocator over a table of fixed memory partitions.
// Input channel (in_valid / in_stall) carries one request word: req_type, size_amount
// and block_index. Output channel (out_valid / out_stall) carries one result word per
// request: status, result_index and result_size. A word moves at a clock edge where
// valid is high and stall is low.
// The block works on one request at a time. An add, and any request rejected at decode,
// goes from decode straight to the holding state; a free first passes through a check of
// the allocated mark, and an allocate through a scan that starts at partition 0 and stops
// at the first partition that fits, or at the last one when nothing fits. The scan reads
// one table entry per cycle through the single read port of the partition memory.
// in_stall drops at the same edge that loads the output register.
// Reset clears the partition count and all control state. The table memory is not
// cleared: an entry's read data is only used below the partition count, and add writes
// the entry (size and a clear allocated mark) at the same edge as the count grows over it.
// When the receiver stalls, the finished result waits in a holding state and no new
// request is taken until the output register frees up; the stalled word stays put.
module first_fit_block_allocator #(
	parameter int NUM_PARTITIONS = ffba_pkg::NUM_PARTITIONS_DEF,
	parameter int SIZE_BITS      = ffba_pkg::SIZE_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [ffba_pkg::REQ_W-1:0]     req_type,
	input  wire logic [ffba_pkg::AMOUNT_W-1:0]  size_amount,
	input  wire logic [ffba_pkg::INDEX_W-1:0]   block_index,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [ffba_pkg::STATUS_W-1:0]       status,
	output logic [ffba_pkg::INDEX_W-1:0]        result_index,
	output logic [ffba_pkg::AMOUNT_W-1:0]       result_size
);

	import ffba_pkg::*;

	localparam int IDXW  = $clog2(NUM_PARTITIONS);
	localparam int CW    = $clog2(NUM_PARTITIONS + 1);
	localparam int CMPW  = (CW > INDEX_W) ? CW : INDEX_W;
	localparam int WORDW = SIZE_BITS + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_FREE_CHK,
		S_HOLD
	} state_t;

	state_t               state_q;
	req_t                 req_q;
	logic [SIZE_BITS-1:0] amount_q;
	logic [INDEX_W-1:0]   bidx_q;
	logic [CW-1:0]        count_q;
	logic [IDXW-1:0]      scan_idx_q;

	// Finished result waiting for the output register.
	status_t              res_status_q;
	logic [INDEX_W-1:0]   res_index_q;
	logic [AMOUNT_W-1:0]  res_size_q;

	logic                 out_valid_q;
	status_t              out_status_q;
	logic [INDEX_W-1:0]   out_index_q;
	logic [AMOUNT_W-1:0]  out_size_q;

	logic                 mem_we;
	logic [IDXW-1:0]      mem_waddr;
	logic [WORDW-1:0]     mem_wdata;
	logic [IDXW-1:0]      mem_raddr;
	logic [WORDW-1:0]     mem_rdata;

	logic                 rd_mark;
	logic [SIZE_BITS-1:0] rd_size;
	logic                 in_fire;
	logic                 out_free;
	logic                 pool_full;
	logic                 free_bad;
	logic                 fit;
	logic                 scan_last;

	ffba_part_mem #(
		.DEPTH (NUM_PARTITIONS),
		.WIDTH (WORDW),
		.ADDR_W(IDXW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Each table word is the allocated mark on top of the partition size.
	assign rd_mark = mem_rdata[WORDW-1];
	assign rd_size = mem_rdata[SIZE_BITS-1:0];

	assign in_stall  = (state_q != S_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign pool_full = (count_q == CW'(NUM_PARTITIONS));
	assign free_bad  = (CMPW'(bidx_q) >= CMPW'(count_q));
	assign fit       = !rd_mark && (rd_size >= amount_q);
	assign scan_last = ((CW'(scan_idx_q) + CW'(1)) == count_q);

	// Memory port control. Reads run one entry ahead of the scan position, so the word
	// for scan_idx_q is on the read data during S_SCAN. Writes only happen when an
	// entry is appended, claimed or released.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = scan_idx_q;
		mem_wdata = {1'b0, amount_q};
		mem_raddr = scan_idx_q + IDXW'(1);
		case (state_q)
			S_DECODE: begin
				mem_raddr = (req_q == REQ_FREE) ? IDXW'(bidx_q) : '0;
				if (req_q == REQ_ADD && !pool_full) begin
					mem_we    = 1'b1;
					mem_waddr = IDXW'(count_q);
					mem_wdata = {1'b0, amount_q};
				end
			end
			S_SCAN: begin
				if (fit) begin
					mem_we    = 1'b1;
					mem_waddr = scan_idx_q;
					mem_wdata = {1'b1, rd_size};
				end
			end
			S_FREE_CHK: begin
				if (rd_mark) begin
					mem_we    = 1'b1;
					mem_waddr = IDXW'(bidx_q);
					mem_wdata = {1'b0, rd_size};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			req_q        <= REQ_ADD;
			amount_q     <= '0;
			bidx_q       <= '0;
			count_q      <= '0;
			scan_idx_q   <= '0;
			res_status_q <= ST_OK;
			res_index_q  <= '0;
			res_size_q   <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_index_q  <= '0;
			out_size_q   <= '0;
		end else begin
			// In S_HOLD the output register is reloaded instead of cleared.
			if (out_valid_q && !out_stall && state_q != S_HOLD) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						req_q    <= req_t'(req_type);
						amount_q <= SIZE_BITS'(size_amount);
						bidx_q   <= block_index;
						state_q  <= S_DECODE;
					end
				end
				S_DECODE: begin
					res_status_q <= ST_BADIDX;
					res_index_q  <= '0;
					res_size_q   <= '0;
					state_q      <= S_HOLD;
					case (req_q)
						REQ_ADD: begin
							if (pool_full) begin
								res_status_q <= ST_FULL;
							end else begin
								res_status_q <= ST_OK;
								res_index_q  <= INDEX_W'(count_q);
								res_size_q   <= AMOUNT_W'(amount_q);
								count_q      <= count_q + CW'(1);
							end
						end
						REQ_ALLOC: begin
							if (count_q == '0) begin
								res_status_q <= ST_NOFIT;
							end else begin
								scan_idx_q <= '0;
								state_q    <= S_SCAN;
							end
						end
						REQ_FREE: begin
							if (!free_bad) begin
								state_q <= S_FREE_CHK;
							end
						end
						default: begin
						end
					endcase
				end
				S_SCAN: begin
					if (fit) begin
						res_status_q <= ST_OK;
						res_index_q  <= INDEX_W'(scan_idx_q);
						res_size_q   <= AMOUNT_W'(rd_size);
						state_q      <= S_HOLD;
					end else if (scan_last) begin
						res_status_q <= ST_NOFIT;
						res_index_q  <= '0;
						res_size_q   <= '0;
						state_q      <= S_HOLD;
					end else begin
						scan_idx_q <= scan_idx_q + IDXW'(1);
					end
				end
				S_FREE_CHK: begin
					if (rd_mark) begin
						res_status_q <= ST_OK;
						res_index_q  <= bidx_q;
						res_size_q   <= AMOUNT_W'(rd_size);
					end else begin
						res_status_q <= ST_FREED;
						res_index_q  <= '0;
						res_size_q   <= '0;
					end
					state_q <= S_HOLD;
				end
				S_HOLD: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_index_q  <= res_index_q;
						out_size_q   <= res_size_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign result_index = out_index_q;
	assign result_size  = out_size_q;

	// The partition count never passes the table depth and never shrinks.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(NUM_PARTITIONS))
		else $error("partition count beyond table depth");

	a_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= $past(count_q))
		else $error("partition count decreased");

	// Writes land on a live entry or on the next one to be appended.
	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (CW'(mem_waddr) <= count_q))
		else $error("table write outside the live range");

	// The scan never reaches an entry that was never added.
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (CW'(scan_idx_q) < count_q))
		else $error("scan past the partition count");

	// A new result word only appears when a request was being worked on.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_HOLD))
		else $error("result word without a finished request");

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import ffba_pkg::*;

	// Table depth of the block under test; it runs with its default parameters.
	localparam int NUM_PARTS     = NUM_PARTITIONS_DEF;
	// The slowest request is an allocate that scans the whole table.
	// The quiet time at the end covers that with some margin.
	localparam int TAIL_CYCLES   = NUM_PARTS + 16;
	// Cycles with no word moving on either channel before the run is declared hung.
	// A correct run never comes close: the long receiver hold-off is the worst stretch.
	localparam int STUCK_LIMIT   = 4000;
	// No idling on either side once this few words remain.
	localparam int QUIET_TAIL    = 120;
	// The receiver holds off once for a long stretch after this many results.
	localparam int LONG_HOLD_AT  = 250;
	localparam int LONG_HOLD_LEN = 200;
	localparam int RANDOM_WORDS  = 680;

	// One request word as it goes onto the input channel.
	typedef struct packed {
		req_t                kind;
		logic [AMOUNT_W-1:0] amount;
		logic [INDEX_W-1:0]  index;
	} request_t;

	// A request waiting to be sent. When drain_first is set, the sender holds it back
	// until every earlier request has returned its result.
	typedef struct {
		request_t word;
		bit       drain_first;
	} queued_request_t;

	// One result word: status, partition index and that partition's size.
	typedef struct packed {
		status_t             st;
		logic [INDEX_W-1:0]  index;
		logic [AMOUNT_W-1:0] size;
	} grant_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [REQ_W-1:0]    req_type = '0;
	logic [AMOUNT_W-1:0] size_amount = '0;
	logic [INDEX_W-1:0]  block_index = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [INDEX_W-1:0]  result_index;
	logic [AMOUNT_W-1:0] result_size;

	first_fit_block_allocator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.size_amount  (size_amount),
		.block_index  (block_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.result_index (result_index),
		.result_size  (result_size)
	);

	always #5 clk = ~clk;

	// Free-running cycle count, used by the watchdog to see how long nothing has moved.
	int cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Requests still to be sent, filled once by the stimulus block at time zero.
	queued_request_t request_q [$];
	// Results that accepted requests must still return, oldest first.
	grant_t          grant_q [$];

	// Handshake counters. All but total_words (set once before reset) change by nonblocking
	// assignment only, so both channel processes see the same values at a given edge.
	int words_sent      = 0;
	int results_seen    = 0;
	int last_in_accept  = 0;
	int last_out_accept = 0;
	int total_words     = 0;

	int  failures = 0;
	bit  run_done = 1'b0;
	int  kind_seen [4];
	int  status_seen [8];

	// Shadow of the partition table. Sizes are only read below the shadow count,
	// so entries that were never added are never looked at.
	logic [AMOUNT_W-1:0] shadow_size [NUM_PARTS];
	bit                  shadow_taken [NUM_PARTS];
	int                  shadow_count = 0;

	// Applies one request to the shadow table and returns the result the block must
	// give for it. Errors always carry a zero index and size.
	function automatic grant_t serve_request(input request_t w);
		grant_t g;
		bit     found;
		int     i;
		g.st    = ST_BADIDX;
		g.index = '0;
		g.size  = '0;
		found   = 1'b0;
		case (w.kind)
			REQ_ADD: begin
				if (shadow_count >= NUM_PARTS) begin
					g.st = ST_FULL;
				end else begin
					shadow_size[shadow_count]  = w.amount;
					shadow_taken[shadow_count] = 1'b0;
					g.st    = ST_OK;
					g.index = shadow_count[INDEX_W-1:0];
					g.size  = w.amount;
					shadow_count++;
				end
			end
			REQ_ALLOC: begin
				// First fit: the lowest free partition that is large enough wins.
				g.st = ST_NOFIT;
				for (i = 0; i < shadow_count; i++) begin
					if (!found && !shadow_taken[i] && shadow_size[i] >= w.amount) begin
						found           = 1'b1;
						shadow_taken[i] = 1'b1;
						g.st            = ST_OK;
						g.index         = i[INDEX_W-1:0];
						g.size          = shadow_size[i];
					end
				end
			end
			REQ_FREE: begin
				if (w.index >= shadow_count) begin
					g.st = ST_BADIDX;
				end else if (!shadow_taken[w.index]) begin
					g.st = ST_FREED;
				end else begin
					shadow_taken[w.index] = 1'b0;
					g.st    = ST_OK;
					g.index = w.index;
					g.size  = shadow_size[w.index];
				end
			end
			default: begin
				// The unused request type is rejected like a bad index.
				g.st = ST_BADIDX;
			end
		endcase
		return g;
	endfunction

	task automatic queue_word(input req_t kind, input logic [AMOUNT_W-1:0] amount,
			input int index, input bit drain_first);
		queued_request_t q;
		q.word.kind   = kind;
		q.word.amount = amount;
		q.word.index  = index[INDEX_W-1:0];
		q.drain_first = drain_first;
		request_q.push_back(q);
	endtask

	// Sender. On each edge it first notes whether the word on the bus was taken, and
	// if so runs it through the shadow table. It then decides what the bus carries
	// next: the held word while stalled, an idle cycle, or the next queued word.
	// Idle bursts are of random length and their rate is redrawn every 50 words,
	// so some stretches have no gaps at all.
	request_t word_on_bus;
	int       gap_left     = 0;
	int       send_gap_pct = 10;
	int       words_offered = 0;

	always @(posedge clk) begin : drive_requests
		bit took;
		int in_flight;
		if (arst_n) begin
			took = in_valid && !in_stall;
			if (took) begin
				grant_q.push_back(serve_request(word_on_bus));
				kind_seen[word_on_bus.kind]++;
				words_sent     <= words_sent + 1;
				last_in_accept <= cycle_count;
			end
			// Requests accepted but not yet answered, counting the one taken just now.
			in_flight = words_sent - results_seen + took;
			if (!in_valid || took) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (request_q.size() == 0 ||
						(request_q[0].drain_first && in_flight != 0)) begin
					in_valid <= 1'b0;
				end else if (request_q.size() > QUIET_TAIL &&
						$urandom_range(0, 99) < send_gap_pct) begin
					// This cycle is the first of the burst.
					gap_left = int'($urandom_range(0, 11));
					in_valid <= 1'b0;
				end else begin
					word_on_bus = request_q[0].word;
					request_q.pop_front();
					in_valid    <= 1'b1;
					req_type    <= word_on_bus.kind;
					size_amount <= word_on_bus.amount;
					block_index <= word_on_bus.index;
					words_offered++;
					if (words_offered % 50 == 0) begin
						case ($urandom_range(0, 2))
							0: send_gap_pct = 0;
							1: send_gap_pct = 10;
							default: send_gap_pct = 35;
						endcase
					end
				end
			end
		end
	end

	// Receiver. Each result word taken is compared with the oldest expectation. The
	// stall pattern is random bursts, plus one long hold-off that lets the block fill
	// up and push back on the sender while it keeps offering words.
	int stall_left     = 0;
	int hold_left      = 0;
	bit long_hold_done = 1'b0;
	int recv_stall_pct = 10;

	always @(posedge clk) begin : collect_results
		grant_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen    <= results_seen + 1;
				last_out_accept <= cycle_count;
				if (results_seen == words_sent) begin
					// Every request sent so far has already been answered.
					failures++;
					if (failures <= 10)
						$display({"Result word with no request waiting: ",
							"status %0d index %0d size %0h"},
							status, result_index, result_size);
				end else begin
					want = grant_q.pop_front();
					status_seen[want.st]++;
					if (status !== want.st || result_index !== want.index ||
							result_size !== want.size) begin
						failures++;
						if (failures <= 10)
							$display({"Mismatch on result %0d: status %0d/%0d ",
								"index %0d/%0d size %0h/%0h (expected/actual)"},
								results_seen, want.st, status, want.index, result_index,
								want.size, result_size);
					end
				end
			end
			if (cycle_count % 97 == 0) begin
				case ($urandom_range(0, 2))
					0: recv_stall_pct = 0;
					1: recv_stall_pct = 10;
					default: recv_stall_pct = 35;
				endcase
			end
			if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
				long_hold_done = 1'b1;
				hold_left      = LONG_HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (results_seen + QUIET_TAIL < total_words &&
					$urandom_range(0, 99) < recv_stall_pct) begin
				stall_left = int'($urandom_range(0, 11));
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Ends the run if no word has moved on either channel for too long.
	initial begin : watchdog
		bit stuck;
		stuck = 1'b0;
		while (!run_done && !stuck) begin
			@(posedge clk);
			stuck = (cycle_count - last_in_accept > STUCK_LIMIT) &&
				(cycle_count - last_out_accept > STUCK_LIMIT);
		end
		if (stuck) begin
			$display("No word moved on either channel for %0d cycles.", STUCK_LIMIT);
			$display("TB_ERROR");
			$finish;
		end
	end

	// Builds the whole request stream, releases reset and waits for the end.
	initial begin : run_test
		logic [AMOUNT_W-1:0] added_sizes [$];
		logic [AMOUNT_W-1:0] amt;
		int                  made;
		int                  pick;
		int                  n;
		int                  idx;
		req_t                kind;

		// Directed opening. The table starts empty, so allocate and free fail first.
		queue_word(REQ_ALLOC, 16'h0000, 0, 1'b0);   // nothing to fit into
		queue_word(REQ_FREE,  16'h0000, 0, 1'b0);   // index beyond an empty table
		queue_word(REQ_RSVD,  16'hffff, 63, 1'b0);  // unused request type
		queue_word(REQ_ADD,   16'h0000, 0, 1'b0);   // partition 0, size zero
		queue_word(REQ_ADD,   16'hffff, 0, 1'b0);   // partition 1, largest size
		queue_word(REQ_ADD,   16'h0001, 0, 1'b0);   // partition 2
		queue_word(REQ_ADD,   16'h8000, 0, 1'b0);   // partition 3
		queue_word(REQ_ALLOC, 16'h0000, 0, 1'b0);   // zero size takes the lowest free one
		queue_word(REQ_ALLOC, 16'hffff, 0, 1'b0);   // only partition 1 is big enough
		queue_word(REQ_ALLOC, 16'h8001, 0, 1'b0);   // one above partition 3: no fit
		queue_word(REQ_ALLOC, 16'h8000, 0, 1'b0);   // exact fit on partition 3
		queue_word(REQ_ALLOC, 16'h0001, 0, 1'b0);   // partition 2
		queue_word(REQ_ALLOC, 16'h0000, 0, 1'b0);   // every partition taken
		queue_word(REQ_FREE,  16'h0000, 1, 1'b0);   // gives back partition 1
		queue_word(REQ_FREE,  16'h0000, 1, 1'b0);   // already free
		queue_word(REQ_FREE,  16'h0000, 4, 1'b0);   // index equal to the count
		queue_word(REQ_FREE,  16'hffff, 63, 1'b0);  // top index, all bits set
		queue_word(REQ_ALLOC, 16'h0002, 0, 1'b0);   // skips taken 0, lands on 1
		queue_word(REQ_FREE,  16'h0000, 0, 1'b0);
		queue_word(REQ_ALLOC, 16'h5555, 42, 1'b0);  // only the zero-size one is free
		queue_word(REQ_RSVD,  16'haaaa, 21, 1'b0);
		queue_word(REQ_FREE,  16'h0000, 3, 1'b0);
		made = 4;
		added_sizes = '{16'h0000, 16'hffff, 16'h0001, 16'h8000};

		// Random part. While the table grows, adds are common; once it is full they
		// become rare and the mix turns to allocate and free churn. Frees mostly name
		// an existing partition, allocations often ask for a size near one that exists.
		for (n = 0; n < RANDOM_WORDS; n++) begin
			pick = int'($urandom_range(0, 99));
			if (made < NUM_PARTS) begin
				if (pick < 30)      kind = REQ_ADD;
				else if (pick < 63) kind = REQ_ALLOC;
				else if (pick < 95) kind = REQ_FREE;
				else                kind = REQ_RSVD;
			end else begin
				if (pick < 8)       kind = REQ_ADD;
				else if (pick < 52) kind = REQ_ALLOC;
				else if (pick < 96) kind = REQ_FREE;
				else                kind = REQ_RSVD;
			end
			pick = int'($urandom_range(0, 99));
			case (kind)
				REQ_ADD: begin
					if (pick < 40)      amt = AMOUNT_W'($urandom_range(0, 255));
					else if (pick < 55) amt = AMOUNT_W'($urandom_range(256, 4095));
					else if (pick < 85) amt = AMOUNT_W'($urandom);
					else begin
						case ($urandom_range(0, 3))
							0: amt = '0;
							1: amt = '1;
							2: amt = 16'h8000;
							default: amt = 16'h7fff;
						endcase
					end
					if (made < NUM_PARTS) begin
						added_sizes.push_back(amt);
						made++;
					end
				end
				REQ_ALLOC: begin
					if (pick < 50) begin
						amt = added_sizes[$urandom_range(0, added_sizes.size() - 1)];
						case ($urandom_range(0, 2))
							0: if (amt != '0) amt--;
							1: if (amt != '1) amt++;
							default: ;
						endcase
					end else if (pick < 75) begin
						amt = AMOUNT_W'($urandom_range(0, 255));
					end else if (pick < 95) begin
						amt = AMOUNT_W'($urandom);
					end else begin
						amt = '0;
					end
				end
				default: begin
					// Free and the unused type ignore the size field.
					amt = AMOUNT_W'($urandom);
				end
			endcase
			if (kind == REQ_FREE && $urandom_range(0, 9) != 0)
				idx = int'($urandom_range(0, made - 1));
			else
				idx = int'($urandom_range(0, 63));
			// Twice in the run the sender waits for every result before going on.
			queue_word(kind, amt, idx, n == 150 || n == 480);
		end
		total_words = request_q.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Wait until every word is sent and answered; the watchdog covers a hang.
		while (request_q.size() != 0 || in_valid || words_sent != results_seen)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (grant_q.size() != 0) begin
			failures += grant_q.size();
			$display("%0d expected result(s) never arrived.", grant_q.size());
		end
		run_done = 1'b1;

		$display("Covered %0d requests: %0d add, %0d allocate, %0d free, %0d unused type.",
			words_sent, kind_seen[REQ_ADD], kind_seen[REQ_ALLOC], kind_seen[REQ_FREE],
			kind_seen[REQ_RSVD]);
		$display({"Outcomes: %0d ok, %0d pool full, %0d no fit, %0d bad index, ",
			"%0d already free; %0d failure(s)."},
			status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_NOFIT],
			status_seen[ST_BADIDX], status_seen[ST_FREED], failures);
		if (failures == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
